// ----- hw/rtl/phpm_pkg.sv -----
// ----------------------------------------------------------------------------
// phpm_pkg: shared definitions for the hex nibble pattern matcher
// Sizes, register indexes and types used by the matcher and its ports.
// ----------------------------------------------------------------------------
package phpm_pkg;

   // Longest pattern, in hex nibbles, and the widths that follow from it.
   localparam int MaxPatNib = 32;
   localparam int NibIdxW   = $clog2(MaxPatNib);
   localparam int NibCntW   = $clog2(MaxPatNib + 1);

   // Fixed field widths of the ports.
   localparam int PatWordW  = 64;
   localparam int PatLenW   = 6;
   localparam int DepthW    = 16;
   localparam int CsrIdxW   = 2;
   localparam int ReqDataW  = 8;
   localparam int RspDataW  = 8;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CsrPatternLow  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrPatternHigh = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrPatternNibs = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrDepthLimit  = 2'd3;

   typedef logic [MaxPatNib-1:0][3:0] nib_vec_type;
   typedef logic [2*PatWordW/4-1:0][3:0] pat_all_type;

endpackage

// ----- hw/rtl/packet_hex_pattern_match.sv -----
// ----------------------------------------------------------------------------
// packet_hex_pattern_match: hex nibble pattern search over packet bytes
// Path: an accepted byte goes to the input register; the result of a last byte
//   is then registered in the result register and presented on rsp_tvalid.
// Throughput: one byte per cycle; a final byte waits while the result is
//   held, but the separate result register never stops non-final bytes.
// Reset: synchronous, active high; clears the valid, config, packet and result state.
// ----------------------------------------------------------------------------
module packet_hex_pattern_match (
   input  logic                           clock,
   input  logic                           reset,
   // Input stream. req_tdata: [7:0] pkt_byte.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [phpm_pkg::ReqDataW-1:0]  req_tdata,
   input  logic                           req_tlast,   // last_byte
   // Result stream. rsp_tdata: [0] matched, [7:1] zero.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [phpm_pkg::RspDataW-1:0]  rsp_tdata,
   // Configuration write channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [phpm_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [phpm_pkg::PatWordW-1:0]  csr_data
);
   import phpm_pkg::*;

   // Configuration registers, as written.
   logic [PatWordW-1:0] pat_low_ff, pat_high_ff;
   logic [PatLenW-1:0]  pat_nibs_ff;
   logic [DepthW-1:0]   depth_ff;

   // The pattern, aligned to the history window: entry j holds the nibble
   // that must sit j places behind the newest one, and care bit j says
   // whether entry j is part of the pattern at all. It is built straight
   // from the configuration registers, so a write counts from the next
   // compare.
   nib_vec_type          cmp_nib;
   logic [MaxPatNib-1:0] care_mask;
   logic [NibCntW-1:0]   pat_len;

   // Input register holding one accepted byte.
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic                s1_last_ff;
   logic                s1_go;

   // Per-packet search state.
   nib_vec_type          hist_ff, hist_in;
   logic [NibCntW-1:0]   nib_cnt_ff, nib_cnt_in;
   logic [DepthW-1:0]    byte_cnt_ff, byte_cnt_in;
   logic                 found_ff, found_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_match_ff, rsp_match_in;

   // Working signals of the compare.
   nib_vec_type          hist_one, hist_two;
   logic [NibCntW-1:0]   cnt_one, cnt_two;
   logic                 in_depth, hit_one, hit_two, found_all;
   pat_all_type          pat_all;

   // A window compare: every pattern entry must equal its history entry.
   function automatic logic window_eq(nib_vec_type h, nib_vec_type c,
                                      logic [MaxPatNib-1:0] m);
      logic eq;
      eq = 1'b1;
      for (int j = 0; j < MaxPatNib; j++) begin
         if (m[j] && (h[j] != c[j])) eq = 1'b0;
      end
      return eq;
   endfunction

   function automatic logic [NibCntW-1:0] sat_inc(logic [NibCntW-1:0] c);
      return (c >= NibCntW'(MaxPatNib)) ? NibCntW'(MaxPatNib) : c + 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Configuration port. Writes are always taken.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_nibs_ff <= '0;
         depth_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrPatternLow:  pat_low_ff  <= csr_data;
            CsrPatternHigh: pat_high_ff <= csr_data;
            CsrPatternNibs: pat_nibs_ff <= csr_data[PatLenW-1:0];
            CsrDepthLimit:  depth_ff    <= csr_data[DepthW-1:0];
            default: ;
         endcase
      end
   end

   // Pattern alignment. A length above the maximum counts as the maximum.
   always_comb begin
      pat_all = {pat_high_ff, pat_low_ff};
      if (pat_nibs_ff > PatLenW'(MaxPatNib)) begin
         pat_len = NibCntW'(MaxPatNib);
      end else begin
         pat_len = NibCntW'(pat_nibs_ff);
      end
      for (int j = 0; j < MaxPatNib; j++) begin
         care_mask[j] = (j < int'(pat_len));
         if (care_mask[j]) begin
            cmp_nib[j] = pat_all[NibIdxW'(int'(pat_len) - 1 - j)];
         end else begin
            cmp_nib[j] = 4'h0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Flow control. A non-final byte always moves on; a final byte needs
   // the result register to be free or draining this cycle.
   // ------------------------------------------------------------------
   assign s1_go       = s1_valid_ff &&
                        (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_go;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                        (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // Search. The two nibbles of the byte are pushed in turn, high first,
   // and the window is compared after each push, so both the even and the
   // odd nibble offsets are covered in the same cycle.
   // ------------------------------------------------------------------
   always_comb begin
      in_depth = (depth_ff == '0) || (byte_cnt_ff < depth_ff);

      hist_one = {hist_ff[MaxPatNib-2:0], s1_byte_ff[7:4]};
      hist_two = {hist_ff[MaxPatNib-3:0], s1_byte_ff[7:4], s1_byte_ff[3:0]};
      cnt_one  = sat_inc(nib_cnt_ff);
      cnt_two  = sat_inc(cnt_one);

      hit_one = (pat_len != '0) && (cnt_one >= pat_len) &&
                window_eq(hist_one, cmp_nib, care_mask);
      hit_two = (pat_len != '0) && (cnt_two >= pat_len) &&
                window_eq(hist_two, cmp_nib, care_mask);

      found_all = found_ff || (in_depth && (hit_one || hit_two));

      // Defaults hold the state.
      hist_in     = hist_ff;
      nib_cnt_in  = nib_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      found_in    = found_ff;

      if (s1_go) begin
         if (s1_last_ff) begin
            // End of packet: the result is taken and the state starts over.
            hist_in     = '0;
            nib_cnt_in  = '0;
            byte_cnt_in = '0;
            found_in    = 1'b0;
         end else begin
            if (in_depth) begin
               hist_in    = hist_two;
               nib_cnt_in = cnt_two;
            end
            if (byte_cnt_ff != '1) byte_cnt_in = byte_cnt_ff + 1'b1;
            found_in = found_all;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         nib_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
         found_ff    <= 1'b0;
      end else begin
         hist_ff     <= hist_in;
         nib_cnt_ff  <= nib_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         found_ff    <= found_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. An empty pattern matches every packet.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = found_all || (pat_len == '0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_match_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_match_ff <= rsp_match_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RspDataW - 1)'(0), rsp_match_ff};

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // A final byte must not be overwritten while its result cannot leave.
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while a final byte is blocked");

   // An empty pattern always yields a match.
   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff && (pat_len == '0) |=> rsp_tvalid && rsp_tdata[0])
      else $error("empty pattern did not report a match");

   // Packet state starts over after each final byte.
   a_packet_clear: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> (nib_cnt_ff == '0) && (byte_cnt_ff == '0) && !found_ff)
      else $error("packet state not cleared after final byte");

   // The nibble count saturates at the window size.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      nib_cnt_ff <= NibCntW'(MaxPatNib))
      else $error("nibble count beyond window size");

endmodule
